// File: sv/dlnt_pkg.sv
// Shared types, constants and widths of the display-list name table.
package dlnt_pkg;

  localparam int LIST_COUNT        = 64;
  localparam int COMMANDS_PER_LIST = 1024;

  localparam int IDX_W = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
  localparam int RUN_W = $clog2(LIST_COUNT + 1);
  localparam int CNT_W = $clog2(COMMANDS_PER_LIST + 1);

  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_DELETE  = 3'd1,
    CMD_OPEN    = 3'd2,
    CMD_CLOSE   = 3'd3,
    CMD_CAPTURE = 3'd4,
    CMD_REFUSE  = 3'd5,
    CMD_QUERY   = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_VALUE     = 3'd1,
    ERR_ENUM      = 3'd2,
    ERR_OPERATION = 3'd3,
    ERR_MEMORY    = 3'd4
  } err_e;

  localparam logic [1:0] MODE_COMPILE = 2'd0;
  localparam logic [1:0] MODE_LAST    = 2'd1;

  typedef enum logic [1:0] {
    TOP_NONE     = 2'd0,
    TOP_SET_SLOT = 2'd1,
    TOP_SET_COMP = 2'd2,
    TOP_CNT_WR   = 2'd3
  } tbl_op_e;

  typedef struct packed {
    tbl_op_e          op;
    logic [IDX_W-1:0] idx;
    logic             used;
    logic [CNT_W-1:0] cnt;
  } tbl_req_t;

  typedef struct packed {
    logic             used;
    logic             compiled;
    logic [CNT_W-1:0] cnt;
  } tbl_rsp_t;

  typedef struct packed {
    logic [15:0] first_name;
    logic        flag;
    err_e        error_code;
  } result_t;

endpackage

// File: sv/dlnt_table.sv
// Slot storage: used and compiled flags in flip-flops, command counts in a memory.
module dlnt_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dlnt_pkg::tbl_req_t req_i,
  output dlnt_pkg::tbl_rsp_t rsp_o
);

  logic [dlnt_pkg::LIST_COUNT-1:0] used_q;
  logic [dlnt_pkg::LIST_COUNT-1:0] comp_q;
  logic [dlnt_pkg::LIST_COUNT-1:0] cntv_q;
  logic [dlnt_pkg::CNT_W-1:0]      cnt_mem [dlnt_pkg::LIST_COUNT];
  logic [dlnt_pkg::CNT_W-1:0]      rd_cnt_q;
  logic                            rd_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      comp_q <= '0;
      cntv_q <= '0;
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= cntv_q[req_i.idx];
      unique case (req_i.op)
        dlnt_pkg::TOP_SET_SLOT: begin
          used_q[req_i.idx] <= req_i.used;
          comp_q[req_i.idx] <= 1'b0;
          cntv_q[req_i.idx] <= 1'b0;
        end
        dlnt_pkg::TOP_SET_COMP: comp_q[req_i.idx] <= 1'b1;
        dlnt_pkg::TOP_CNT_WR:   cntv_q[req_i.idx] <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rd_cnt_q <= cnt_mem[req_i.idx];
    if (req_i.op == dlnt_pkg::TOP_CNT_WR) begin
      cnt_mem[req_i.idx] <= req_i.cnt;
    end
  end

  // A count never written since its slot was cleared reads as zero.
  assign rsp_o.used     = used_q[req_i.idx];
  assign rsp_o.compiled = comp_q[req_i.idx];
  assign rsp_o.cnt      = rd_v_q ? rd_cnt_q : '0;

endmodule

// File: sv/dlnt_ctrl.sv
// Command sequencer with the slot walker shared by allocate and delete.
module dlnt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  dlnt_pkg::cmd_e     cmd_i,
  input  logic [15:0]        name_i,
  input  logic [15:0]        count_i,
  input  logic [1:0]         mode_i,
  input  logic               take_i,
  output logic               ready_o,
  output logic               done_o,
  output dlnt_pkg::result_t  res_o,
  output dlnt_pkg::tbl_req_t req_o,
  input  dlnt_pkg::tbl_rsp_t rsp_i
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECODE = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_SWEEP  = 6'b001000,
    ST_CAPT   = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  localparam logic [16:0] LC17 = 17'(dlnt_pkg::LIST_COUNT);

  state_e                     state_q, state_d;
  dlnt_pkg::cmd_e             cmd_q;
  logic [15:0]                name_q;
  logic [14:0]                cnt_q;
  logic                       neg_q;
  logic [1:0]                 mode_q;
  logic [dlnt_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [dlnt_pkg::IDX_W-1:0] hi_q, hi_d;
  logic [dlnt_pkg::RUN_W-1:0] run_q, run_d;
  logic                       sweep_used_q, sweep_used_d;
  logic                       open_valid_q, open_valid_d;
  logic [dlnt_pkg::IDX_W-1:0] open_idx_q, open_idx_d;
  logic                       open_mode_q, open_mode_d;
  dlnt_pkg::result_t          res_q, res_d;

  logic                       name_ok;
  logic [16:0]                lo, hi, hi_clip;
  logic                       del_empty;
  logic [dlnt_pkg::RUN_W-1:0] run_inc;
  logic [dlnt_pkg::IDX_W-1:0] run_start;

  always_comb begin
    name_ok   = (name_q != 16'd0) && ({1'b0, name_q} <= LC17);
    lo        = (name_q == 16'd0) ? 17'd1 : {1'b0, name_q};
    hi        = {1'b0, name_q} + {2'b00, cnt_q} - 17'd1;
    hi_clip   = (hi > LC17) ? LC17 : hi;
    del_empty = (cnt_q == 15'd0) || (lo > LC17) || (hi < lo);
    run_inc   = run_q + dlnt_pkg::RUN_W'(1);
    run_start = idx_q - dlnt_pkg::IDX_W'(cnt_q) + dlnt_pkg::IDX_W'(1);
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    hi_d         = hi_q;
    run_d        = run_q;
    sweep_used_d = sweep_used_q;
    open_valid_d = open_valid_q;
    open_idx_d   = open_idx_q;
    open_mode_d  = open_mode_q;
    res_d        = res_q;
    req_o.op     = dlnt_pkg::TOP_NONE;
    req_o.idx    = idx_q;
    req_o.used   = sweep_used_q;
    req_o.cnt    = rsp_i.cnt + dlnt_pkg::CNT_W'(1);

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          res_d   = '{first_name: 16'd0, flag: 1'b0, error_code: dlnt_pkg::ERR_NONE};
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_DONE;
        unique case (cmd_q)
          dlnt_pkg::CMD_ALLOC: begin
            if (neg_q) begin
              res_d.error_code = dlnt_pkg::ERR_VALUE;
            end else if ((cnt_q != 15'd0) && ({2'b00, cnt_q} <= LC17)) begin
              idx_d   = '0;
              run_d   = '0;
              state_d = ST_SCAN;
            end
          end
          dlnt_pkg::CMD_DELETE: begin
            if (neg_q) begin
              res_d.error_code = dlnt_pkg::ERR_VALUE;
            end else if (!del_empty) begin
              idx_d        = dlnt_pkg::IDX_W'(lo - 17'd1);
              hi_d         = dlnt_pkg::IDX_W'(hi_clip - 17'd1);
              sweep_used_d = 1'b0;
              state_d      = ST_SWEEP;
            end
          end
          dlnt_pkg::CMD_OPEN: begin
            req_o.idx = dlnt_pkg::IDX_W'(name_q - 16'd1);
            if (mode_q > dlnt_pkg::MODE_LAST) begin
              res_d.error_code = dlnt_pkg::ERR_ENUM;
            end else if (!name_ok) begin
              res_d.error_code = dlnt_pkg::ERR_VALUE;
            end else if (open_valid_q) begin
              res_d.error_code = dlnt_pkg::ERR_OPERATION;
            end else begin
              req_o.op     = dlnt_pkg::TOP_SET_SLOT;
              req_o.used   = 1'b1;
              open_valid_d = 1'b1;
              open_idx_d   = dlnt_pkg::IDX_W'(name_q - 16'd1);
              open_mode_d  = mode_q[0];
            end
          end
          dlnt_pkg::CMD_CLOSE: begin
            req_o.idx = open_idx_q;
            if (!open_valid_q) begin
              res_d.error_code = dlnt_pkg::ERR_OPERATION;
            end else begin
              req_o.op     = dlnt_pkg::TOP_SET_COMP;
              open_valid_d = 1'b0;
            end
          end
          dlnt_pkg::CMD_CAPTURE: begin
            req_o.idx = open_idx_q;
            if (open_valid_q) begin
              state_d = ST_CAPT;
            end
          end
          dlnt_pkg::CMD_REFUSE: begin
            if (open_valid_q) begin
              res_d.error_code = dlnt_pkg::ERR_OPERATION;
              res_d.flag       = 1'b1;
            end
          end
          dlnt_pkg::CMD_QUERY: begin
            req_o.idx  = dlnt_pkg::IDX_W'(name_q - 16'd1);
            res_d.flag = name_ok && rsp_i.used && rsp_i.compiled;
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        // First-fit search: run_q counts free slots ending just before idx_q.
        if (!rsp_i.used && (15'(run_inc) == cnt_q)) begin
          res_d.first_name = 16'(run_start) + 16'd1;
          hi_d             = idx_q;
          idx_d            = run_start;
          sweep_used_d     = 1'b1;
          state_d          = ST_SWEEP;
        end else begin
          run_d = rsp_i.used ? '0 : run_inc;
          if (idx_q == dlnt_pkg::IDX_W'(dlnt_pkg::LIST_COUNT - 1)) begin
            state_d = ST_DONE;
          end else begin
            idx_d = idx_q + dlnt_pkg::IDX_W'(1);
          end
        end
      end
      ST_SWEEP: begin
        req_o.op = dlnt_pkg::TOP_SET_SLOT;
        if (idx_q == hi_q) begin
          state_d = ST_DONE;
        end else begin
          idx_d = idx_q + dlnt_pkg::IDX_W'(1);
        end
      end
      ST_CAPT: begin
        req_o.idx  = open_idx_q;
        res_d.flag = !open_mode_q;
        if (rsp_i.cnt >= dlnt_pkg::CNT_W'(dlnt_pkg::COMMANDS_PER_LIST)) begin
          res_d.error_code = dlnt_pkg::ERR_MEMORY;
        end else begin
          req_o.op = dlnt_pkg::TOP_CNT_WR;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      open_valid_q <= 1'b0;
      open_idx_q   <= '0;
      open_mode_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      open_valid_q <= open_valid_d;
      open_idx_q   <= open_idx_d;
      open_mode_q  <= open_mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == ST_IDLE)) begin
      cmd_q  <= cmd_i;
      name_q <= name_i;
      cnt_q  <= count_i[14:0];
      neg_q  <= count_i[15];
      mode_q <= mode_i;
    end
    idx_q        <= idx_d;
    hi_q         <= hi_d;
    run_q        <= run_d;
    sweep_used_q <= sweep_used_d;
    res_q        <= res_d;
  end

  assign ready_o = (state_q == ST_IDLE);
  assign done_o  = (state_q == ST_DONE);
  assign res_o   = res_q;

endmodule

// File: sv/display_list_name_table.sv
// Top level of the display-list name table: stream ports and output register.
//
// The block keeps LIST_COUNT display-list slots named 1 to LIST_COUNT, with a
// used flag, a compiled flag and a captured-command count for each, and
// remembers which list is open for compilation and in which mode. Each input
// word carries one command and yields exactly one result word. One command is
// in work at a time and the input is not ready meanwhile. Capture with a list
// open passes through an extra state because the count memory has a registered
// read port. Allocate walks the slots one per cycle with the single free-run
// counter, then marks the chosen run one slot per cycle. Delete marks only the
// names in range that are valid, one per cycle. The input is ready again as
// soon as the result has moved into the output register, so a new command may
// be taken while a result still waits to be read. The count memory needs no
// clearing pass: each slot has a valid bit cleared by reset.
module display_list_name_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: list_name[15:0], name_count[31:16], mode[33:32], zero fill.
  input  logic [39:0] s_axis_tdata,
  // Fields from bit 0: command[2:0].
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: first_name[15:0], flag[16], error_code[19:17], zero fill.
  output logic [23:0] m_axis_tdata
);

  dlnt_pkg::tbl_req_t tbl_req;
  dlnt_pkg::tbl_rsp_t tbl_rsp;
  dlnt_pkg::result_t  ctrl_res;
  logic               ctrl_ready;
  logic               ctrl_done;
  logic               in_word;
  logic               out_free;
  logic               load_res;
  logic               m_valid_q;
  logic [23:0]        m_data_q;

  // A word is taken only while the sequencer is idle.
  assign s_axis_tready = ctrl_ready;
  assign in_word       = s_axis_tvalid && ctrl_ready;

  // The output register frees when it is empty or its word is being read.
  assign out_free = !m_valid_q || m_axis_tready;
  assign load_res = ctrl_done && out_free;

  dlnt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_word),
    .cmd_i   (dlnt_pkg::cmd_e'(s_axis_tuser)),
    .name_i  (s_axis_tdata[15:0]),
    .count_i (s_axis_tdata[31:16]),
    .mode_i  (s_axis_tdata[33:32]),
    .take_i  (load_res),
    .ready_o (ctrl_ready),
    .done_o  (ctrl_done),
    .res_o   (ctrl_res),
    .req_o   (tbl_req),
    .rsp_i   (tbl_rsp)
  );

  dlnt_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tbl_req),
    .rsp_o  (tbl_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_res) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      m_data_q <= {4'd0, ctrl_res.error_code, ctrl_res.flag, ctrl_res.first_name};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Once a word has been taken, no other is taken until its result is loaded.
  a_busy_after_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_word |=> !s_axis_tready)
    else $error("input ready straight after a word was taken");

  // A result is loaded only when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready) |=> $stable(m_data_q))
    else $error("pending result overwritten");

  // A found run never comes with an error or a flag.
  a_alloc_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (m_data_q[15:0] != 16'd0)) |-> (m_data_q[19:16] == 4'd0))
    else $error("allocated name with error or flag");

  // Error codes stay within the defined set.
  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_data_q[19:17] <= 3'd4))
    else $error("undefined error code");

endmodule
